// ----- src/glyph_bitmap_blitter_core_macros.svh -----
// Assertion macros for the glyph blitter RTL.
// Each macro expects aclk and aresetn to be visible where it is used.
`ifndef GLYPH_BITMAP_BLITTER_CORE_MACROS_SVH
`define GLYPH_BITMAP_BLITTER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GBB_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("gbb: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GBB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("gbb: next-cycle check failed");

`endif

// ----- src/gbb_pkg.sv -----
// Shared constants, types and color packing functions for the glyph blitter.
// No dependencies; every RTL module file of the block imports this package.
package gbb_pkg;

    // Field widths.
    localparam int BYTE_W   = 8;
    localparam int LEFT_W   = 12;
    localparam int END_W    = 13;
    localparam int CMP_W    = END_W + 1;
    localparam int PITCH_W  = 10;
    localparam int GFMT_W   = 2;
    localparam int ADDR_W   = 26;
    localparam int LB_W     = 15;
    localparam int COLOR_W  = 32;
    localparam int WSIZE_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int BIT_CNT_W = $clog2(BYTE_W);

    // Screen limit for the glyph box.
    localparam int SCREEN_DIM = 4096;

    // Framebuffer pixel formats.
    typedef enum logic [1:0] {
        FB_8BPP  = 2'd0,
        FB_16BPP = 2'd1,
        FB_32BPP = 2'd2,
        FB_NONE  = 2'd3
    } fb_fmt_t;

    // Glyph source formats; any other code is unsupported.
    localparam logic [GFMT_W-1:0] GF_1BPP = 2'd0;
    localparam logic [GFMT_W-1:0] GF_8BPP = 2'd1;

    // Write size codes.
    localparam logic [WSIZE_W-1:0] WS_BYTE = 2'd0;
    localparam logic [WSIZE_W-1:0] WS_HALF = 2'd1;
    localparam logic [WSIZE_W-1:0] WS_WORD = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FB_FORMAT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR   = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [COLOR_W-1:0] FG_RESET = 32'h00FF_FFFF;
    localparam logic [COLOR_W-1:0] BG_RESET = 32'h0000_0000;

    // One result word.
    typedef struct packed {
        logic [ADDR_W-1:0]  byte_addr;
        logic [COLOR_W-1:0] pixel_data;
        logic [WSIZE_W-1:0] write_size;
        logic               fault;
        logic               glyph_done;
        logic               run_last;
    } gbb_word_t;

    // Pack an RGB888 color into the framebuffer format.
    function automatic logic [COLOR_W-1:0] pack_color(fb_fmt_t fmt, logic [COLOR_W-1:0] c);
        logic [COLOR_W-1:0] res;
        unique case (fmt)
            FB_8BPP:  res = {24'd0, c[7:0]};
            FB_16BPP: res = {16'd0, c[23:19], c[15:10], c[7:3]};
            default:  res = c;
        endcase
        return res;
    endfunction

    // Write size code for a framebuffer format.
    function automatic logic [WSIZE_W-1:0] size_code(fb_fmt_t fmt);
        logic [WSIZE_W-1:0] res;
        unique case (fmt)
            FB_8BPP:  res = WS_BYTE;
            FB_16BPP: res = WS_HALF;
            default:  res = WS_WORD;
        endcase
        return res;
    endfunction

    // Log2 of bytes per pixel, used to scale the column into a byte offset.
    function automatic logic [1:0] bpp_shift(fb_fmt_t fmt);
        logic [1:0] res;
        unique case (fmt)
            FB_8BPP:  res = 2'd0;
            FB_16BPP: res = 2'd1;
            default:  res = 2'd2;
        endcase
        return res;
    endfunction

endpackage

// ----- src/gbb_serial_mul.sv -----
// Bit-serial shift-add multiplier for the row base address (top row times line bytes).
// Depends on gbb_pkg; takes one multiplier bit per cycle, MSB first.
module gbb_serial_mul import gbb_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [LB_W-1:0]   mcand,
    input  logic [LEFT_W-1:0] mplier,
    output logic              busy,
    output logic              done,
    output logic [ADDR_W-1:0] product
);

    localparam int CNT_W = $clog2(LEFT_W + 1);

    logic [CNT_W-1:0]  cnt_reg;
    logic [LEFT_W-1:0] mplier_reg;
    logic [LB_W-1:0]   mcand_reg;
    logic [ADDR_W-1:0] acc_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [ADDR_W-1:0] acc_next;

    // One partial product per cycle; the product wraps modulo the address width.
    always_comb begin
        acc_next = {acc_reg[ADDR_W-2:0], 1'b0};
        if (mplier_reg[LEFT_W-1]) begin
            acc_next = acc_next + ADDR_W'(mcand_reg);
        end
    end

    // Control: count the multiplier bits and flag completion.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(LEFT_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath: operands and accumulator.
    always_ff @(posedge aclk) begin
        if (start) begin
            mplier_reg <= mplier;
            mcand_reg  <= mcand;
            acc_reg    <= '0;
        end else if (busy_reg) begin
            mplier_reg <= {mplier_reg[LEFT_W-2:0], 1'b0};
            acc_reg    <= acc_next;
        end
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ----- src/gbb_out_stage.sv -----
// Output register for result words, decoupling the pixel engine from the sink.
// Depends on gbb_pkg for the word type.
module gbb_out_stage import gbb_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load,
    input  gbb_word_t word_in,
    output logic      free,
    input  logic      m_ready,
    output logic      m_valid,
    output gbb_word_t word_out
);

    logic      valid_reg;
    gbb_word_t word_reg;

    // The register can take a new word when empty or when its word leaves now.
    assign free = !valid_reg || m_ready;

    // Valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    // Payload.
    always_ff @(posedge aclk) begin
        if (load && free) begin
            word_reg <= word_in;
        end
    end

    assign m_valid  = valid_reg;
    assign word_out = word_reg;

endmodule

// ----- src/glyph_bitmap_blitter_core.sv -----
// Glyph blitter top level: expands glyph bitmap bytes into framebuffer pixel writes.
// A byte taken passes through the EVAL and PIX states, and each pixel word through the output register.
// The input is held while a byte is walked (1bpp: up to eight pixels per byte, 8bpp: one),
// and a start byte also waits in the MUL state for the bit-serial row address multiply.
// Reset is synchronous, active low; it restores the register defaults and idles.
// Depends on gbb_pkg, gbb_serial_mul, gbb_out_stage and the assertion macro header.
`include "glyph_bitmap_blitter_core_macros.svh"

module glyph_bitmap_blitter_core import gbb_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write port.
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]   cfg_wdata,
    // Input words.
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_glyph_start,
    input  logic [LEFT_W-1:0]    s_left_x,
    input  logic [END_W-1:0]     s_end_x,
    input  logic [LEFT_W-1:0]    s_top_y,
    input  logic [END_W-1:0]     s_end_y,
    input  logic [PITCH_W-1:0]   s_row_pitch,
    input  logic [GFMT_W-1:0]    s_glyph_format,
    input  logic [BYTE_W-1:0]    s_src_byte,
    // Result words.
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [ADDR_W-1:0]    m_byte_addr,
    output logic [COLOR_W-1:0]   m_pixel_data,
    output logic [WSIZE_W-1:0]   m_write_size,
    output logic                 m_fault,
    output logic                 m_glyph_done,
    output logic                 m_run_last
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL   = 6'b000010,
        ST_EVAL  = 6'b000100,
        ST_PIX   = 6'b001000,
        ST_FIN   = 6'b010000,
        ST_FAULT = 6'b100000
    } state_t;

    localparam logic [PITCH_W-1:0] BIR_MAX = '1;

    state_t               state_reg, state_next;

    // Configuration registers.
    fb_fmt_t              fb_format_reg;
    logic [LB_W-1:0]      line_bytes_reg;
    logic [COLOR_W-1:0]   fg_color_reg;
    logic [COLOR_W-1:0]   bg_color_reg;

    // Glyph geometry and walk state.
    logic [LEFT_W-1:0]    left_reg;
    logic [END_W-1:0]     end_x_reg;
    logic [END_W-1:0]     end_y_reg;
    logic [PITCH_W-1:0]   pitch_reg;
    logic [GFMT_W-1:0]    gfmt_reg;
    logic [END_W-1:0]     cur_x_reg;
    logic [END_W-1:0]     cur_y_reg;
    logic [PITCH_W-1:0]   bir_reg;
    logic [ADDR_W-1:0]    row_base_reg;
    logic                 aborted_reg;
    logic                 start_pend_reg;

    // Source bit shifter.
    logic [BYTE_W-1:0]    src_sh_reg;
    logic [BIT_CNT_W-1:0] bit_cnt_reg;

    logic                 in_fire;
    logic                 mul_busy;
    logic                 mul_done;
    logic [ADDR_W-1:0]    mul_product;
    logic                 out_free;
    logic                 out_load;
    gbb_word_t            out_word;
    gbb_word_t            out_q;

    logic [END_W-1:0]     end_x_sat;
    logic [END_W-1:0]     end_y_sat;
    logic [END_W-1:0]     cur_x_inc;
    logic                 pix_fg;
    logic [COLOR_W-1:0]   pix_color;
    logic [ADDR_W-1:0]    pix_addr;
    logic                 pix_done;
    logic                 pix_last;
    logic                 x_past_end;
    logic [PITCH_W-1:0]   bir_inc;
    logic                 fin_new_row;

    assign s_ready = (state_reg == ST_IDLE);
    assign in_fire = s_valid && s_ready;

    // Clamp the box to the screen.
    assign end_x_sat = (CMP_W'(s_end_x) > CMP_W'(SCREEN_DIM)) ? END_W'(SCREEN_DIM) : s_end_x;
    assign end_y_sat = (CMP_W'(s_end_y) > CMP_W'(SCREEN_DIM)) ? END_W'(SCREEN_DIM) : s_end_y;

    // Row base address multiplier, started with each glyph start word.
    gbb_serial_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (in_fire && s_glyph_start),
        .mcand   (line_bytes_reg),
        .mplier  (s_top_y),
        .busy    (mul_busy),
        .done    (mul_done),
        .product (mul_product)
    );

    // Pixel word: color select, packing, address and end-of-glyph detection.
    assign cur_x_inc  = cur_x_reg + END_W'(1);
    assign x_past_end = (cur_x_reg >= end_x_reg);
    assign pix_fg     = (gfmt_reg == GF_8BPP) ? (|src_sh_reg) : src_sh_reg[BYTE_W-1];
    assign pix_color  = pix_fg ? fg_color_reg : bg_color_reg;
    assign pix_addr   = row_base_reg + (ADDR_W'(cur_x_reg) << bpp_shift(fb_format_reg));
    assign pix_done   = (CMP_W'(cur_y_reg) + CMP_W'(1) == CMP_W'(end_y_reg))
                        && (cur_x_inc == end_x_reg);
    assign pix_last   = (gfmt_reg == GF_8BPP) || (bit_cnt_reg == '0)
                        || (cur_x_inc >= end_x_reg);

    // Result word mux: a fault word carries no write.
    always_comb begin
        if (state_reg == ST_FAULT) begin
            out_word = '{byte_addr: '0, pixel_data: '0, write_size: WS_BYTE,
                         fault: 1'b1, glyph_done: 1'b0, run_last: 1'b1};
        end else begin
            out_word = '{byte_addr: pix_addr,
                         pixel_data: pack_color(fb_format_reg, pix_color),
                         write_size: size_code(fb_format_reg),
                         fault: 1'b0, glyph_done: pix_done,
                         run_last: pix_last || pix_done};
        end
    end

    assign out_load = ((state_reg == ST_PIX) || (state_reg == ST_FAULT)) && out_free;

    gbb_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (out_load),
        .word_in  (out_word),
        .free     (out_free),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .word_out (out_q)
    );

    assign m_byte_addr  = out_q.byte_addr;
    assign m_pixel_data = out_q.pixel_data;
    assign m_write_size = out_q.write_size;
    assign m_fault      = out_q.fault;
    assign m_glyph_done = out_q.glyph_done;
    assign m_run_last   = out_q.run_last;

    // Row bookkeeping at the end of a byte.
    assign bir_inc     = (bir_reg == BIR_MAX) ? bir_reg : bir_reg + PITCH_W'(1);
    assign fin_new_row = (gfmt_reg == GF_1BPP) ? (x_past_end && (bir_inc >= pitch_reg))
                                               : x_past_end;

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = s_glyph_start ? ST_MUL : ST_EVAL;
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (start_pend_reg && gfmt_reg[1]) begin
                    state_next = ST_FAULT;
                end else if (start_pend_reg && ((CMP_W'(left_reg) >= CMP_W'(end_x_reg))
                             || (cur_y_reg >= end_y_reg))) begin
                    state_next = ST_IDLE;
                end else if (aborted_reg || (cur_y_reg >= end_y_reg)) begin
                    state_next = ST_IDLE;
                end else if ((gfmt_reg == GF_1BPP) && x_past_end) begin
                    state_next = ST_FIN;
                end else if (fb_format_reg == FB_NONE) begin
                    state_next = ST_FAULT;
                end else begin
                    state_next = ST_PIX;
                end
            end
            ST_PIX: begin
                if (out_free) begin
                    if (pix_done) begin
                        state_next = ST_IDLE;
                    end else if (pix_last) begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                state_next = ST_IDLE;
            end
            ST_FAULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fb_format_reg  <= FB_32BPP;
            line_bytes_reg <= '0;
            fg_color_reg   <= FG_RESET;
            bg_color_reg   <= BG_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FB_FORMAT:  fb_format_reg  <= fb_fmt_t'(cfg_wdata[1:0]);
                CFG_LINE_BYTES: line_bytes_reg <= cfg_wdata[LB_W-1:0];
                CFG_FG_COLOR:   fg_color_reg   <= cfg_wdata;
                CFG_BG_COLOR:   bg_color_reg   <= cfg_wdata;
                default:        fg_color_reg   <= fg_color_reg;
            endcase
        end
    end

    // Sequencer, geometry and walk state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            left_reg       <= '0;
            end_x_reg      <= '0;
            end_y_reg      <= '0;
            pitch_reg      <= '0;
            gfmt_reg       <= GF_1BPP;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            bir_reg        <= '0;
            row_base_reg   <= '0;
            aborted_reg    <= 1'b0;
            start_pend_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        start_pend_reg <= s_glyph_start;
                        if (s_glyph_start) begin
                            left_reg    <= s_left_x;
                            end_x_reg   <= end_x_sat;
                            end_y_reg   <= end_y_sat;
                            pitch_reg   <= s_row_pitch;
                            gfmt_reg    <= s_glyph_format;
                            cur_x_reg   <= END_W'(s_left_x);
                            cur_y_reg   <= END_W'(s_top_y);
                            bir_reg     <= '0;
                            aborted_reg <= 1'b0;
                        end
                    end
                end
                ST_MUL: begin
                    if (mul_done) begin
                        row_base_reg <= mul_product;
                    end
                end
                ST_EVAL: begin
                    start_pend_reg <= 1'b0;
                    if (start_pend_reg && !gfmt_reg[1]
                        && ((CMP_W'(left_reg) >= CMP_W'(end_x_reg))
                            || (cur_y_reg >= end_y_reg))) begin
                        aborted_reg <= 1'b1;
                    end
                end
                ST_PIX: begin
                    if (out_free) begin
                        cur_x_reg <= cur_x_inc;
                        if (pix_done) begin
                            aborted_reg <= 1'b1;
                        end
                    end
                end
                ST_FIN: begin
                    if (fin_new_row) begin
                        cur_y_reg    <= cur_y_reg + END_W'(1);
                        cur_x_reg    <= END_W'(left_reg);
                        bir_reg      <= '0;
                        row_base_reg <= row_base_reg + ADDR_W'(line_bytes_reg);
                    end else if (gfmt_reg == GF_1BPP) begin
                        bir_reg <= bir_inc;
                    end
                end
                ST_FAULT: begin
                    if (out_free) begin
                        aborted_reg <= 1'b1;
                    end
                end
                default: begin
                    aborted_reg <= aborted_reg;
                end
            endcase
        end
    end

    // Source bit shifter: one bit leaves per emitted pixel, MSB first.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            src_sh_reg  <= s_src_byte;
            bit_cnt_reg <= BIT_CNT_W'(BYTE_W - 1);
        end else if ((state_reg == ST_PIX) && out_free) begin
            src_sh_reg  <= {src_sh_reg[BYTE_W-2:0], 1'b0};
            bit_cnt_reg <= bit_cnt_reg - BIT_CNT_W'(1);
        end
    end

    // A fault word never marks a finished glyph and always closes its byte.
    `GBB_ASSERT_IMPL(a_fault_shape, m_valid && m_fault, m_run_last && !m_glyph_done)
    // The final pixel of a glyph is also the last word of its byte.
    `GBB_ASSERT_IMPL(a_done_is_last, m_valid && m_glyph_done, m_run_last)
    // No new word is taken while the row multiplier is still running.
    `GBB_ASSERT_IMPL(a_mul_blocks_input, mul_busy, !s_ready)
    // Emitting the final pixel leaves the block idle until the next glyph start.
    `GBB_ASSERT_NEXT(a_done_aborts, out_load && out_word.glyph_done, aborted_reg)

endmodule
